/* src/b2da_pkg.sv */
// Package for the binary to decimal ASCII converter: sizes, constants and the shift-add-3 step.
`timescale 1ns / 1ps
package b2da_pkg;

  localparam int unsigned ValueWidth     = 32;
  localparam int unsigned NumDigits      = 10;
  localparam int unsigned BcdWidth       = 4 * NumDigits;
  localparam int unsigned WordWidth      = BcdWidth + ValueWidth;
  localparam int unsigned StepsPerStage  = 4;
  localparam int unsigned NumStages      = ValueWidth / StepsPerStage;
  localparam int unsigned DigitIdxWidth  = $clog2(NumDigits);
  localparam int unsigned CharWidth      = 6;
  localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

  typedef logic [WordWidth-1:0]     dd_word_t;
  typedef logic [BcdWidth-1:0]      bcd_t;
  typedef logic [DigitIdxWidth-1:0] digit_idx_t;

  // One double-dabble iteration: correct every BCD digit of five or more, then shift left.
  function automatic dd_word_t dd_step(input dd_word_t x);
    dd_word_t y;
    y = x;
    for (int i = 0; i < NumDigits; i++) begin
      if (y[ValueWidth + 4*i +: 4] >= 4'd5) begin
        y[ValueWidth + 4*i +: 4] = y[ValueWidth + 4*i +: 4] + 4'd3;
      end
    end
    return {y[WordWidth-2:0], 1'b0};
  endfunction

  // Several iterations make up one pipeline stage.
  function automatic dd_word_t dd_stage(input dd_word_t x);
    dd_word_t y;
    y = x;
    for (int s = 0; s < StepsPerStage; s++) begin
      y = dd_step(y);
    end
    return y;
  endfunction

endpackage

/* src/binary_to_decimal_ascii.sv */
// Binary to decimal ASCII converter: pipelined double dabble and character serialiser.
`timescale 1ns / 1ps
// Usage:
//   A request is taken at the rising edge where start_i is high and busy_o is low;
//   value_i carries a 32-bit unsigned number. The block answers with its decimal
//   digits as ASCII codes, most significant first, leading zeros dropped (zero
//   gives a single '0'). Each character sits on digit_char_o / last_o for one
//   cycle with strobe_o high; last_o marks the final character of a run.
//   The first character of a request follows once it has passed the input register,
//   the conversion stages, the serialiser and the output register; then one character per cycle with no gaps.
//   Throughput: the conversion is an input register plus eight stages of four
//   shift-add-3 steps each and takes a request every cycle; the sustained rate
//   is set by the single-character output port, so a request of N digits (1 to 10)
//   occupies the output for N characters. busy_o rises when the pipeline is full
//   behind a running serialiser.
//   Reset clears all valid bits and the strobe; no state is kept between
//   requests. The receiver cannot stall: every strobe is a delivered character.
module binary_to_decimal_ascii (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [b2da_pkg::ValueWidth-1:0]   value_i,
  output logic                              strobe_o,
  output logic [b2da_pkg::CharWidth-1:0]    digit_char_o,
  output logic                              last_o
);
  import b2da_pkg::*;

  // Stage 0 holds the raw request, stage k holds it after 4k iterations.
  dd_word_t             data_q  [0:NumStages];
  logic [NumStages:0]   valid_q;
  logic [NumStages+1:0] free;

  // Serialiser.
  bcd_t       digits_q;
  digit_idx_t idx_q;
  logic       active_q;
  logic       ser_take;
  digit_idx_t lead;

  logic                 strobe_q;
  logic [CharWidth-1:0] char_q;
  logic                 last_q;

  assign ser_take = !active_q || (idx_q == '0);

  // A stage may take new data when empty or when its contents move on.
  always_comb begin
    free[NumStages+1] = ser_take;
    for (int k = NumStages; k >= 0; k--) begin
      free[k] = !valid_q[k] || free[k+1];
    end
  end

  assign busy_o = !free[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (free[0]) begin
      valid_q[0] <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[0] && start_i) begin
      data_q[0] <= {{BcdWidth{1'b0}}, value_i};
    end
  end

  for (genvar k = 1; k <= NumStages; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (free[k]) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (free[k] && valid_q[k-1]) begin
        data_q[k] <= dd_stage(data_q[k-1]);
      end
    end
  end

  // Highest non-zero digit; zero leaves the units digit.
  always_comb begin
    lead = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (data_q[NumStages][ValueWidth + 4*i +: 4] != 4'd0) begin
        lead = DigitIdxWidth'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= active_q;
      if (ser_take) begin
        active_q <= valid_q[NumStages];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_take) begin
      digits_q <= data_q[NumStages][WordWidth-1:ValueWidth];
      idx_q    <= lead;
    end else begin
      idx_q    <= idx_q - 1'b1;
    end
    if (active_q) begin
      char_q <= AsciiZero + {2'b00, digits_q[4*idx_q +: 4]};
      last_q <= (idx_q == '0);
    end
  end

  assign strobe_o     = strobe_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

endmodule
